@@ rtl/assert_macros.svh @@
// Assertion macros shared by the zero run encoder modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, off during rst.
`define ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// Next-cycle implication, sampled on clk, off during rst.
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

@@ rtl/zre_pkg.sv @@
// Shared widths, constants and types of the zero run encoder.
package zre_pkg;

  localparam int VALUE_WIDTH  = 32;
  localparam int COUNT_WIDTH  = 32;
  localparam int LENGTH_WIDTH = 24;

  // Results one item can cause: run pair plus value or failure beat.
  localparam int MAX_RESULTS = 3;
  localparam int NUM_WIDTH   = $clog2(MAX_RESULTS + 1);
  localparam int POS_WIDTH   = $clog2(MAX_RESULTS);

  // Queue between front and back.
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_WIDTH  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_WIDTH  = $clog2(QUEUE_DEPTH + 1);

  typedef logic [VALUE_WIDTH-1:0]  value_t;
  typedef logic [COUNT_WIDTH-1:0]  count_t;
  typedef logic [LENGTH_WIDTH-1:0] length_t;

  localparam count_t COUNT_MAX = '1;

  // Encoded results of one item, oldest in slot 0.
  typedef struct packed {
    value_t [MAX_RESULTS-1:0] words;
    logic [NUM_WIDTH-1:0]     num;       // beats held, 1..MAX_RESULTS
    logic                     blk_end;   // final beat closes the block
    logic                     fail;      // final beat is the failure beat
  } zre_entry_t;

  // Queue occupancy flags seen by front and back.
  typedef struct packed {
    logic full;
    logic empty;
  } zre_qstat_t;

  // Run length placed on the word field.
  function automatic value_t count_word(input count_t c);
    return value_t'(c);
  endfunction

endpackage

@@ rtl/zero_run_encoder_unit.sv @@
// Zero run encoder top level: front end, entry queue and output sequencer.
//
//  channel   direction  handshake                        payload
//  item      in         item_valid / item_ready          value[31:0]
//  result    out        result_valid / result_ready      word[31:0] run_last block_end status
//  config    in         block_length_write (no wait)     block_length[23:0]
//
// An item yields one to three result beats; the output register sends one beat per cycle
// while result_ready is high. Items whose words are all swallowed (inside a zero run,
// after a failure) yield no beats and do not enter the queue.
// The two-entry queue lets the front keep taking items while the output stalls.
// Reset (rst, synchronous) sets block_length to 1 and clears block state and queue.

module zero_run_encoder_unit (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   block_length_write,
  input  logic [23:0]            block_length,
  input  logic                   item_valid,
  output logic                   item_ready,
  input  logic [31:0]            value,
  output logic                   result_valid,
  input  logic                   result_ready,
  output logic [31:0]            word,
  output logic                   run_last,
  output logic                   block_end,
  output logic                   status
);

  zre_pkg::zre_qstat_t qstat;
  zre_pkg::zre_entry_t push_entry;
  zre_pkg::zre_entry_t head;
  logic                push;
  logic                pop;

  zre_front u_front (
    .clk                (clk),
    .rst                (rst),
    .block_length_write (block_length_write),
    .block_length       (block_length),
    .item_valid         (item_valid),
    .item_ready         (item_ready),
    .value              (value),
    .qstat              (qstat),
    .push               (push),
    .push_entry         (push_entry)
  );

  zre_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .qstat      (qstat)
  );

  zre_back u_back (
    .clk          (clk),
    .rst          (rst),
    .head         (head),
    .qstat        (qstat),
    .pop          (pop),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .word         (word),
    .run_last     (run_last),
    .block_end    (block_end),
    .status       (status)
  );

endmodule

@@ rtl/zre_front.sv @@
// Front end: accepts words, tracks block state and builds result entries.
`include "assert_macros.svh"

module zre_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                block_length_write,
  input  zre_pkg::length_t    block_length,
  input  logic                item_valid,
  output logic                item_ready,
  input  zre_pkg::value_t     value,
  input  zre_pkg::zre_qstat_t qstat,
  output logic                push,
  output zre_pkg::zre_entry_t push_entry
);

  // Block state
  zre_pkg::length_t len_reg;
  zre_pkg::count_t  zero_run;
  zre_pkg::length_t items_seen;
  zre_pkg::length_t words_out;
  logic             aborted;

  zre_pkg::count_t  zero_run_next;
  zre_pkg::length_t words_out_next;
  logic             fail;

  zre_pkg::length_t          len;
  zre_pkg::length_t          left;
  logic                      last;
  logic                      fire;
  logic [zre_pkg::COUNT_WIDTH-1:0] run_inc;
  logic [zre_pkg::LENGTH_WIDTH:0]  seen_inc;

  assign item_ready = !qstat.full;
  assign fire       = item_valid && item_ready;

  // Budget and end-of-block checks
  always_comb begin
    len      = (len_reg == '0) ? zre_pkg::length_t'(1) : len_reg;
    left     = (len > words_out) ? len - words_out : '0;
    seen_inc = {1'b0, items_seen} + (zre_pkg::LENGTH_WIDTH+1)'(1);
    last     = seen_inc >= {1'b0, len};
    run_inc  = zero_run + zre_pkg::count_t'(1);
  end

  // Encoding of one word
  always_comb begin
    push_entry       = '0;
    zero_run_next    = zero_run;
    words_out_next   = words_out;
    fail             = 1'b0;
    if (value != '0) begin
      zero_run_next = '0;
      if (zero_run != '0) begin
        if (left < zre_pkg::length_t'(2)) begin
          fail           = 1'b1;
          push_entry.num = zre_pkg::NUM_WIDTH'(1);
        end else if (left < zre_pkg::length_t'(3)) begin
          // pair fits, value does not
          fail                = 1'b1;
          push_entry.words[1] = zre_pkg::count_word(zero_run);
          push_entry.num      = zre_pkg::NUM_WIDTH'(3);
          words_out_next      = words_out + zre_pkg::length_t'(2);
        end else begin
          push_entry.words[1] = zre_pkg::count_word(zero_run);
          push_entry.words[2] = value;
          push_entry.num      = zre_pkg::NUM_WIDTH'(3);
          words_out_next      = words_out + zre_pkg::length_t'(3);
        end
      end else if (left == '0) begin
        fail           = 1'b1;
        push_entry.num = zre_pkg::NUM_WIDTH'(1);
      end else begin
        push_entry.words[0] = value;
        push_entry.num      = zre_pkg::NUM_WIDTH'(1);
        words_out_next      = words_out + zre_pkg::length_t'(1);
      end
    end else begin
      if (run_inc == zre_pkg::COUNT_MAX) begin
        // run saturates: flush at the maximum count
        zero_run_next = '0;
        if (left < zre_pkg::length_t'(2)) begin
          fail           = 1'b1;
          push_entry.num = zre_pkg::NUM_WIDTH'(1);
        end else begin
          push_entry.words[1] = zre_pkg::count_word(zre_pkg::COUNT_MAX);
          push_entry.num      = zre_pkg::NUM_WIDTH'(2);
          words_out_next      = words_out + zre_pkg::length_t'(2);
        end
      end else begin
        zero_run_next = run_inc;
        if (last) begin
          // end of block flushes the pending run
          if (left < zre_pkg::length_t'(2)) begin
            fail           = 1'b1;
            push_entry.num = zre_pkg::NUM_WIDTH'(1);
          end else begin
            push_entry.words[1] = zre_pkg::count_word(run_inc);
            push_entry.num      = zre_pkg::NUM_WIDTH'(2);
            words_out_next      = words_out + zre_pkg::length_t'(2);
          end
        end
      end
    end
    push_entry.fail    = fail;
    push_entry.blk_end = last || fail;
    if (aborted) begin
      push_entry.num = '0;
    end
  end

  assign push = fire && (push_entry.num != '0);

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      len_reg    <= zre_pkg::length_t'(1);
      zero_run   <= '0;
      items_seen <= '0;
      words_out  <= '0;
      aborted    <= 1'b0;
    end else if (block_length_write) begin
      len_reg    <= block_length;
      zero_run   <= '0;
      items_seen <= '0;
      words_out  <= '0;
      aborted    <= 1'b0;
    end else if (fire) begin
      if (last) begin
        zero_run   <= '0;
        items_seen <= '0;
        words_out  <= '0;
        aborted    <= 1'b0;
      end else begin
        items_seen <= seen_inc[zre_pkg::LENGTH_WIDTH-1:0];
        if (!aborted) begin
          zero_run  <= zero_run_next;
          words_out <= words_out_next;
          aborted   <= fail;
        end
      end
    end
  end

  // Checks
  `ASSERT_NEXT(a_abort_holds, fire && !block_length_write && !aborted && fail && !last, aborted)
  `ASSERT_IMPL(a_budget, 1'b1, words_out <= len)

endmodule

@@ rtl/zre_queue.sv @@
// Short entry queue between the front end and the output sequencer.
`include "assert_macros.svh"

module zre_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  zre_pkg::zre_entry_t push_entry,
  input  logic                pop,
  output zre_pkg::zre_entry_t head,
  output zre_pkg::zre_qstat_t qstat
);

  zre_pkg::zre_entry_t mem [zre_pkg::QUEUE_DEPTH];
  logic [zre_pkg::QPTR_WIDTH-1:0] wr_ptr;
  logic [zre_pkg::QPTR_WIDTH-1:0] rd_ptr;
  logic [zre_pkg::QCNT_WIDTH-1:0] count;

  localparam logic [zre_pkg::QPTR_WIDTH-1:0] PTR_LAST =
    zre_pkg::QPTR_WIDTH'(zre_pkg::QUEUE_DEPTH - 1);

  assign head        = mem[rd_ptr];
  assign qstat.full  = count == zre_pkg::QCNT_WIDTH'(zre_pkg::QUEUE_DEPTH);
  assign qstat.empty = count == '0;

  // Entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_entry;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + zre_pkg::QPTR_WIDTH'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + zre_pkg::QPTR_WIDTH'(1);
      end
      if (push && !pop) begin
        count <= count + zre_pkg::QCNT_WIDTH'(1);
      end else if (pop && !push) begin
        count <= count - zre_pkg::QCNT_WIDTH'(1);
      end
    end
  end

  // Checks
  `ASSERT_IMPL(a_no_overflow, push, !qstat.full)
  `ASSERT_IMPL(a_no_underflow, pop, !qstat.empty)
  `ASSERT_IMPL(a_entry_nonempty, push, push_entry.num != '0)

endmodule

@@ rtl/zre_back.sv @@
// Output sequencer: plays each queued entry out one beat at a time.
`include "assert_macros.svh"

module zre_back (
  input  logic                clk,
  input  logic                rst,
  input  zre_pkg::zre_entry_t head,
  input  zre_pkg::zre_qstat_t qstat,
  output logic                pop,
  output logic                result_valid,
  input  logic                result_ready,
  output zre_pkg::value_t     word,
  output logic                run_last,
  output logic                block_end,
  output logic                status
);

  logic [zre_pkg::POS_WIDTH-1:0] pos;
  logic                          load;
  logic                          final_beat;
  zre_pkg::value_t               cur_word;

  // Next beat of the head entry
  always_comb begin
    load       = !qstat.empty && (!result_valid || result_ready);
    final_beat = (zre_pkg::NUM_WIDTH'(pos) + zre_pkg::NUM_WIDTH'(1)) == head.num;
    cur_word   = head.words[pos];
  end

  assign pop = load && final_beat;

  // Beat position within the entry
  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= '0;
    end else if (load) begin
      pos <= final_beat ? '0 : pos + zre_pkg::POS_WIDTH'(1);
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (load) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      word      <= cur_word;
      run_last  <= final_beat;
      block_end <= final_beat && head.blk_end;
      status    <= final_beat && head.fail;
    end
  end

  // Checks
  `ASSERT_IMPL(a_pos_in_entry, !qstat.empty, zre_pkg::NUM_WIDTH'(pos) < head.num)
  `ASSERT_NEXT(a_hold_stalled, result_valid && !result_ready, result_valid)
  `ASSERT_IMPL(a_status_last, result_valid && status, run_last && block_end)

endmodule

@@ bench/zre_result_checker.sv @@
// Result checker for the zero run encoder: predicts the encoded beats and compares them.
module zre_result_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        block_length_write,
  input  logic [23:0] block_length,
  input  logic        item_valid,
  input  logic        item_ready,
  input  logic [31:0] value,
  input  logic        result_valid,
  input  logic        result_ready,
  input  logic [31:0] word,
  input  logic        run_last,
  input  logic        block_end,
  input  logic        status,
  output int          errors,
  output int          pending,
  output int          beats_checked,
  output int          budget_fails
);
  timeunit 1ns;
  timeprecision 1ps;

  // One encoded output beat
  typedef struct packed {
    zre_pkg::value_t word;
    logic            run_last;
    logic            block_end;
    logic            status;
  } enc_beat_t;

  localparam zre_pkg::count_t RUN_FULL = '1;

  // Encoder state as seen from outside
  zre_pkg::length_t               blk_len;
  zre_pkg::count_t                zero_run;
  zre_pkg::length_t               items_seen;
  logic [zre_pkg::LENGTH_WIDTH:0] words_out;
  bit                             aborted;

  enc_beat_t expected_beats[$];
  enc_beat_t item_beats[$];

  function void clear_block();
    zero_run   = '0;
    items_seen = '0;
    words_out  = '0;
    aborted    = 1'b0;
  endfunction

  // Append one beat to those of the current item
  function void add_beat(input enc_beat_t b);
    item_beats.insert(item_beats.size(), b);
  endfunction

  // Output budget still open for n more words
  function bit has_room(input zre_pkg::length_t eff_len, input int n);
    return (eff_len > words_out) && (eff_len - words_out >= n);
  endfunction

  // Zero marker plus run length; refused when the budget is short
  function bit emit_run(input zre_pkg::length_t eff_len, input zre_pkg::count_t cnt);
    if (!has_room(eff_len, 2)) return 1'b0;
    add_beat('{zre_pkg::value_t'(0), 1'b0, 1'b0, 1'b0});
    add_beat('{zre_pkg::value_t'(cnt), 1'b0, 1'b0, 1'b0});
    words_out = (zre_pkg::LENGTH_WIDTH+1)'(words_out + 2);
    return 1'b1;
  endfunction

  // Expected beats caused by one accepted input word
  task automatic encode_value(input zre_pkg::value_t v);
    zre_pkg::length_t eff_len;
    bit               last_item;
    bit               ok;
    eff_len   = (blk_len == 0) ? zre_pkg::length_t'(1) : blk_len;
    last_item = (items_seen + 1 >= eff_len);
    ok        = 1'b1;
    item_beats.delete();
    if (!aborted) begin
      if (v != 0) begin
        if (zero_run != 0) begin
          ok = emit_run(eff_len, zero_run);
          zero_run = '0;
        end
        if (ok) begin
          if (!has_room(eff_len, 1)) begin
            ok = 1'b0;
          end else begin
            add_beat('{v, 1'b0, 1'b0, 1'b0});
            words_out = (zre_pkg::LENGTH_WIDTH+1)'(words_out + 1);
          end
        end
      end else begin
        zero_run = zero_run + 1;
        // counter saturates: flush a full run at once
        if (zero_run == RUN_FULL) begin
          ok = emit_run(eff_len, RUN_FULL);
          zero_run = '0;
        end
      end
      // pending run closes with the block
      if (ok && last_item && zero_run != 0) begin
        ok = emit_run(eff_len, zero_run);
        zero_run = '0;
      end
      if (!ok) begin
        add_beat('{zre_pkg::value_t'(0), 1'b0, 1'b1, 1'b1});
        aborted = 1'b1;
        budget_fails++;
      end else if (last_item && item_beats.size() > 0) begin
        item_beats[item_beats.size()-1].block_end = 1'b1;
      end
      if (item_beats.size() > 0) item_beats[item_beats.size()-1].run_last = 1'b1;
      expected_beats = {expected_beats, item_beats};
    end
    items_seen = zre_pkg::length_t'(items_seen + 1);
    if (last_item) clear_block();
  endtask

  // Sample all channels at the rising edge
  always @(posedge clk) begin
    enc_beat_t got;
    enc_beat_t want;
    if (rst) begin
      blk_len = zre_pkg::length_t'(1);
      clear_block();
      expected_beats.delete();
    end else begin
      if (result_valid && result_ready) begin
        got = '{word, run_last, block_end, status};
        if (expected_beats.size() == 0) begin
          errors++;
          $display("%t: unexpected beat: word=%h run_last=%b block_end=%b status=%b",
                   $time, word, run_last, block_end, status);
        end else begin
          want = expected_beats.pop_front();
          beats_checked++;
          if (got !== want) begin
            errors++;
            $display("%t: mismatch: expected word=%h run_last=%b block_end=%b status=%b",
                     $time, want.word, want.run_last, want.block_end, want.status);
            $display("%t:           actual word=%h run_last=%b block_end=%b status=%b",
                     $time, word, run_last, block_end, status);
          end
        end
      end
      if (block_length_write) begin
        blk_len = block_length;
        clear_block();
      end
      if (item_valid && item_ready) encode_value(value);
    end
    pending = expected_beats.size();
  end

endmodule

@@ bench/zero_run_encoder_unit_tb.sv @@
// Testbench top for the zero run encoder: clock, reset, stimulus and verdict.
module zero_run_encoder_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        block_length_write = 1'b0;
  logic [23:0] block_length = '0;
  logic        item_valid = 1'b0;
  logic        item_ready;
  logic [31:0] value = '0;
  logic        result_valid;
  logic        result_ready = 1'b0;
  logic [31:0] word;
  logic        run_last;
  logic        block_end;
  logic        status;

  int errors;
  int pending;
  int beats_checked;
  int budget_fails;

  int items_sent   = 0;
  int settings     = 0;
  int hold_cycles  = 0;   // long receiver stall request
  bit no_idle      = 1'b0;

  zero_run_encoder_unit DUT (
    .clk                (clk),
    .rst                (rst),
    .block_length_write (block_length_write),
    .block_length       (block_length),
    .item_valid         (item_valid),
    .item_ready         (item_ready),
    .value              (value),
    .result_valid       (result_valid),
    .result_ready       (result_ready),
    .word               (word),
    .run_last           (run_last),
    .block_end          (block_end),
    .status             (status)
  );

  zre_result_checker checker_i (
    .clk                (clk),
    .rst                (rst),
    .block_length_write (block_length_write),
    .block_length       (block_length),
    .item_valid         (item_valid),
    .item_ready         (item_ready),
    .value              (value),
    .result_valid       (result_valid),
    .result_ready       (result_ready),
    .word               (word),
    .run_last           (run_last),
    .block_end          (block_end),
    .status             (status),
    .errors             (errors),
    .pending            (pending),
    .beats_checked      (beats_checked),
    .budget_fails       (budget_fails)
  );

  // 8 ns clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Offer one word; returns at the falling edge after its beat, valid still high
  task automatic send_value(input zre_pkg::value_t v);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    item_valid <= 1'b1;
    value      <= v;
    @(posedge clk);
    while (!item_ready) @(posedge clk);
    @(negedge clk);
    items_sent++;
  endtask

  // Drain, let in-flight words settle, then write the block length
  task automatic set_length(input zre_pkg::length_t len);
    item_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (12) @(negedge clk);
    block_length_write <= 1'b1;
    block_length       <= len;
    @(negedge clk);
    block_length_write <= 1'b0;
    settings++;
  endtask

  // Random words, zero_pct percent of them zero
  task automatic send_block(input int count, input int zero_pct);
    zre_pkg::value_t v;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 99) < zero_pct) begin
        v = '0;
      end else begin
        case ($urandom_range(0, 3))
          0: v = '1;
          1: v = zre_pkg::value_t'($urandom_range(1, 255));
          2: v = zre_pkg::value_t'(1) << $urandom_range(0, 31);
          default: begin
            v = $urandom;
            if (v == 0) v = 1;
          end
        endcase
      end
      send_value(v);
    end
  endtask

  // Result side: random ready gaps plus requested long stalls
  initial begin
    int stall;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      stall = (no_idle ? 0 : $urandom_range(0, 9)) + hold_cycles;
      hold_cycles = 0;
      if (stall > 0) begin
        result_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      result_ready <= 1'b1;
      @(posedge clk);
      while (!result_valid) @(posedge clk);
      @(negedge clk);
    end
  end

  // Stimulus and verdict
  initial begin
    zre_pkg::length_t len;
    int               blocks;
    int               zero_pct;
    int               phase;
    repeat (5) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // reset length of one: every word closes its own block
    send_value('1);
    send_value(32'h0);
    send_value(32'h8000_0000);
    send_value(32'h1);

    // zero length behaves as one
    set_length(24'd0);
    send_value(32'h0);
    send_value(32'h7);

    // full-budget zero run, then a trailing run that no longer fits
    set_length(24'd4);
    repeat (4) send_value(32'h0);
    send_value(32'h5);
    send_value(32'h0);
    send_value(32'h6);
    send_value(32'h0);

    // pair emitted, value overflows: three beats, then a swallowed word
    set_length(24'd5);
    send_value(32'h0);
    send_value(32'h1);
    send_value(32'h0);
    send_value(32'h2);
    send_value(32'h3);

    // sender pauses mid-block until the output has drained
    set_length(24'd6);
    send_value(32'h0);
    send_value(32'h0);
    send_value(32'h1);
    item_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    send_value(32'h0);
    send_value(32'h0);
    send_value(32'h2);

    // output held off while input keeps coming: queue fills, input stalls
    set_length(24'd16);
    no_idle = 1'b1;
    hold_cycles = 300;
    send_block(16, 0);
    no_idle = 1'b0;

    // random blocks over a range of lengths
    phase = 0;
    while (items_sent < 300) begin
      case (phase % 8)
        0: len = 24'd1;
        1: len = 24'd2;
        2: len = 24'd3;
        3: len = zre_pkg::length_t'($urandom_range(4, 12));
        4: len = 24'd16;
        5: len = 24'd0;
        6: len = zre_pkg::length_t'($urandom_range(1, 40));
        default: len = 24'hFF_FFFF;
      endcase
      set_length(len);
      no_idle = ($urandom_range(0, 3) == 0);
      if (len == 24'hFF_FFFF) begin
        // block never completes; the next write starts over
        send_block(24, $urandom_range(0, 60));
      end else begin
        blocks = $urandom_range(1, 4);
        repeat (blocks) begin
          if ($urandom_range(0, 3) == 0) zero_pct = $urandom_range(50, 100);
          else zero_pct = $urandom_range(0, 20);
          send_block((len == 0) ? 1 : int'(len), zero_pct);
        end
      end
      no_idle = 1'b0;
      phase++;
    end

    item_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (20) @(negedge clk);

    $display("Sent %0d words over %0d block length settings, checked %0d result beats,",
             items_sent, settings, beats_checked);
    $display("%0d blocks cut short by the output budget.", budget_fails);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
